// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame parser modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion violated");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");

`endif

// ===== src/scfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial command frame parser package
// Frame characters, result kinds and the event record passed between stages.
// ---------------------------------------------------------------------------
package scfp_pkg;

  // frame characters
  localparam logic [7:0] CH_START = 8'h26;
  localparam logic [7:0] CH_STOP  = 8'h24;
  localparam logic [7:0] CH_SEP   = 8'h3A;
  localparam logic [7:0] CH_ACK   = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // one queued event: a read reply or a full acknowledge burst
  typedef struct packed {
    logic       is_ack;
    logic [7:0] ack_id;
    logic [7:0] sender;
    logic [7:0] blocks;
    logic [7:0] read_char;
  } event_t;

endpackage

// ===== src/serial_command_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Serial command frame parser
// Parses received command frames, stores their blocks and answers reads.
// ---------------------------------------------------------------------------
// The block takes one input transfer per clock. A received byte walks the
// frame '&' id ':' length ':' (command ':' message ':') x length ackid ':'
// check '$'; a read transfer presents one stored character with the sender
// and block count on the output via the input register, event queue and
// serializer register. The closing '$' yields five output transfers (the
// acknowledge bytes '&' 'A' ackid '$', then a frame-done transfer with
// tlast), one per cycle while the output is ready, along the same path.
// Events wait in a four-entry queue between the parser and the output
// serializer, so input keeps flowing at one transfer per cycle until that
// queue fills; the output side then sets the rate at one transfer per
// cycle. No clearing pass runs after reset: unwritten blocks read as zero.
module serial_command_frame_parser #(
  parameter int MAX_BLOCKS  = 3,
  parameter int COMMAND_LEN = 3,
  parameter int MESSAGE_LEN = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // rx_byte[7:0], read_block[9:8], read_pos[13:10], zero
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // tx_byte, frame_sender, frame_blocks, read_char
  output logic [1:0]  m_tuser,  // kind
  output logic        m_tlast
);

  logic             pe_valid;
  logic             pe_ready;
  scfp_pkg::event_t pe_data;
  logic             qe_valid;
  logic             qe_ready;
  scfp_pkg::event_t qe_data;
  logic [7:0]       tx_byte;
  logic [7:0]       frame_sender;
  logic [7:0]       frame_blocks;
  logic [7:0]       read_char;

  // parse state and storage
  scfp_parser #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .COMMAND_LEN (COMMAND_LEN),
    .MESSAGE_LEN (MESSAGE_LEN)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_byte   (s_tdata[7:0]),
    .in_blk    (s_tdata[9:8]),
    .in_pos    (s_tdata[13:10]),
    .evt_valid (pe_valid),
    .evt_ready (pe_ready),
    .evt       (pe_data)
  );

  // pending events
  scfp_event_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (pe_valid),
    .push_ready (pe_ready),
    .push_data  (pe_data),
    .pop_valid  (qe_valid),
    .pop_ready  (qe_ready),
    .pop_data   (qe_data)
  );

  // result transfers
  scfp_ack_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (qe_valid),
    .evt_ready  (qe_ready),
    .evt        (qe_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_tx     (tx_byte),
    .out_sender (frame_sender),
    .out_blocks (frame_blocks),
    .out_char   (read_char),
    .out_last   (m_tlast)
  );

  assign m_tdata = {read_char, frame_blocks, frame_sender, tx_byte};

endmodule

// ===== src/scfp_parser.sv =====
// ---------------------------------------------------------------------------
// Frame parser core
// Input register, parse state machine, block text storage and read lookup.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scfp_parser #(
  parameter int MAX_BLOCKS  = 3,
  parameter int COMMAND_LEN = 3,
  parameter int MESSAGE_LEN = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [7:0]          in_byte,
  input  logic [1:0]          in_blk,
  input  logic [3:0]          in_pos,
  output logic                evt_valid,
  input  logic                evt_ready,
  output scfp_pkg::event_t    evt
);

  localparam int BlockSize = COMMAND_LEN + MESSAGE_LEN;
  localparam int PosW      = $clog2(BlockSize);
  localparam int BlkW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SlotW     = $clog2(MAX_BLOCKS + 1);
  localparam int CfW       = $clog2(COMMAND_LEN + 1);
  localparam int MfW       = $clog2(MESSAGE_LEN + 1);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN   = 3'd2,
    PH_CMD   = 3'd3,
    PH_MSG   = 3'd4,
    PH_ACKID = 3'd5,
    PH_CHECK = 3'd7
  } phase_t;

  typedef logic [BlockSize-1:0][7:0] text_t;

  // input register
  logic       hold;
  logic       mode_q;
  logic [7:0] byte_q;
  logic [1:0] blk_q;
  logic [3:0] pos_q;

  // parse state
  phase_t           phase, phase_next;
  logic [7:0]       sender_id, sender_id_next;
  logic [7:0]       block_total, block_total_next;
  logic [7:0]       blocks_left, blocks_left_next;
  logic [SlotW-1:0] block_slot, block_slot_next;
  logic [CfW-1:0]   command_fill, command_fill_next;
  logic [MfW-1:0]   message_fill, message_fill_next;
  logic [7:0]       ack_id, ack_id_next;
  text_t            work_text, work_text_next;

  // stored blocks, one row per block
  text_t                 rows [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] row_valid;
  logic                  row_we;
  logic [BlkW-1:0]       row_waddr;
  text_t                 row_wdata;

  logic       is_stop;
  logic       need_push;
  logic       advance;
  logic [7:0] rd_char;
  logic [PosW-1:0] msg_idx;

  // handshake: an item moves on unless its event finds the queue full
  assign is_stop   = (phase == PH_CHECK) && (byte_q == scfp_pkg::CH_STOP);
  assign need_push = mode_q || is_stop;
  assign advance   = hold && (!need_push || evt_ready);
  assign in_ready  = !hold || advance;
  assign evt_valid = hold && need_push;

  // read lookup, unwritten rows read as zero
  always_comb begin
    rd_char = 8'h00;
    if (int'(blk_q) < MAX_BLOCKS && int'(pos_q) < BlockSize) begin
      if (row_valid[BlkW'(blk_q)]) begin
        rd_char = rows[BlkW'(blk_q)][PosW'(pos_q)];
      end
    end
  end

  // event record
  always_comb begin
    evt.is_ack    = !mode_q;
    evt.ack_id    = ack_id;
    evt.sender    = sender_id;
    evt.blocks    = block_total;
    evt.read_char = rd_char;
  end

  assign msg_idx = PosW'(COMMAND_LEN + int'(message_fill));

  // next parse state
  always_comb begin
    logic [7:0] bl_dec;
    text_t      commit_row;
    phase_next        = phase;
    sender_id_next    = sender_id;
    block_total_next  = block_total;
    blocks_left_next  = blocks_left;
    block_slot_next   = block_slot;
    command_fill_next = command_fill;
    message_fill_next = message_fill;
    ack_id_next       = ack_id;
    work_text_next    = work_text;
    bl_dec            = blocks_left - 8'd1;
    commit_row        = work_text;
    if (int'(message_fill) < MESSAGE_LEN) begin
      commit_row[msg_idx] = 8'h00;
    end
    row_we    = 1'b0;
    row_waddr = BlkW'(block_slot);
    row_wdata = commit_row;
    if (advance && !mode_q) begin
      unique case (phase)
        PH_START: begin
          if (byte_q == scfp_pkg::CH_START) begin
            sender_id_next    = '0;
            block_total_next  = '0;
            blocks_left_next  = '0;
            block_slot_next   = '0;
            command_fill_next = '0;
            message_fill_next = '0;
            phase_next        = PH_ID;
          end
        end
        PH_ID: begin
          if (byte_q == scfp_pkg::CH_SEP) begin
            phase_next = PH_LEN;
          end else begin
            sender_id_next = byte_q;
          end
        end
        PH_LEN: begin
          if (byte_q == scfp_pkg::CH_SEP) begin
            phase_next = PH_CMD;
          end else begin
            block_total_next = byte_q - scfp_pkg::CH_ZERO;
            blocks_left_next = byte_q - scfp_pkg::CH_ZERO;
          end
        end
        PH_CMD: begin
          if (byte_q == scfp_pkg::CH_SEP) begin
            if (int'(command_fill) < COMMAND_LEN) begin
              work_text_next[PosW'(command_fill)] = 8'h00;
            end
            phase_next = PH_MSG;
          end else if (int'(command_fill) < COMMAND_LEN) begin
            work_text_next[PosW'(command_fill)] = byte_q;
            command_fill_next = command_fill + 1'b1;
          end
        end
        PH_MSG: begin
          if (byte_q == scfp_pkg::CH_SEP) begin
            // block complete: store it while a slot is free
            if (int'(block_slot) < MAX_BLOCKS) begin
              row_we          = 1'b1;
              block_slot_next = block_slot + 1'b1;
            end
            work_text_next    = '0;
            command_fill_next = '0;
            message_fill_next = '0;
            blocks_left_next  = bl_dec;
            phase_next        = (bl_dec == 8'd0) ? PH_ACKID : PH_CMD;
          end else if (int'(message_fill) < MESSAGE_LEN) begin
            work_text_next[msg_idx] = byte_q;
            message_fill_next = message_fill + 1'b1;
          end
        end
        PH_ACKID: begin
          if (byte_q == scfp_pkg::CH_SEP) begin
            phase_next = PH_CHECK;
          end else begin
            ack_id_next = byte_q;
          end
        end
        PH_CHECK: begin
          if (is_stop) begin
            phase_next = PH_START;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

  // state and input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold         <= 1'b0;
      phase        <= PH_START;
      sender_id    <= '0;
      block_total  <= '0;
      blocks_left  <= '0;
      block_slot   <= '0;
      command_fill <= '0;
      message_fill <= '0;
      ack_id       <= '0;
      work_text    <= '0;
      row_valid    <= '0;
    end else begin
      if (in_ready) begin
        hold <= in_valid;
      end
      phase        <= phase_next;
      sender_id    <= sender_id_next;
      block_total  <= block_total_next;
      blocks_left  <= blocks_left_next;
      block_slot   <= block_slot_next;
      command_fill <= command_fill_next;
      message_fill <= message_fill_next;
      ack_id       <= ack_id_next;
      work_text    <= work_text_next;
      if (row_we) begin
        row_valid[row_waddr] <= 1'b1;
      end
    end
    if (in_valid && in_ready) begin
      mode_q <= in_mode;
      byte_q <= in_byte;
      blk_q  <= in_blk;
      pos_q  <= in_pos;
    end
    if (row_we) begin
      rows[row_waddr] <= row_wdata;
    end
  end

  // slot and fill counters stay within their limits
  `ASSERT_ALWAYS(slot_bound, clk, rst, int'(block_slot) <= MAX_BLOCKS)
  `ASSERT_ALWAYS(fill_bound, clk, rst,
    int'(command_fill) <= COMMAND_LEN && int'(message_fill) <= MESSAGE_LEN)

endmodule

// ===== src/scfp_event_fifo.sv =====
// ---------------------------------------------------------------------------
// Event queue
// Small register queue that decouples the parser from the result serializer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scfp_event_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  scfp_pkg::event_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output scfp_pkg::event_t pop_data
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  scfp_pkg::event_t mem [Depth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [PtrW:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != (PtrW + 1)'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  `ASSERT_ALWAYS(count_bound, clk, rst, count <= (PtrW + 1)'(Depth))

endmodule

// ===== src/scfp_ack_serializer.sv =====
// ---------------------------------------------------------------------------
// Result serializer
// Expands each queued event into its result transfers on the output channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scfp_ack_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_valid,
  output logic             evt_ready,
  input  scfp_pkg::event_t evt,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_tx,
  output logic [7:0]       out_sender,
  output logic [7:0]       out_blocks,
  output logic [7:0]       out_char,
  output logic             out_last
);

  // beats of an acknowledge burst
  localparam logic [2:0] BeatOpen  = 3'd0;
  localparam logic [2:0] BeatAck   = 3'd1;
  localparam logic [2:0] BeatId    = 3'd2;
  localparam logic [2:0] BeatClose = 3'd3;
  localparam logic [2:0] BeatDone  = 3'd4;

  scfp_pkg::event_t cur;
  logic             cur_valid;
  logic [2:0]       beat;
  logic             is_last;
  logic             fire;

  assign is_last   = !cur.is_ack || (beat == BeatDone);
  assign fire      = cur_valid && out_ready;
  assign evt_ready = !cur_valid || (fire && is_last);

  // current event and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat      <= BeatOpen;
    end else if (evt_ready) begin
      cur_valid <= evt_valid;
      beat      <= BeatOpen;
    end else if (fire) begin
      beat <= beat + 3'd1;
    end
    if (evt_valid && evt_ready) begin
      cur <= evt;
    end
  end

  // result fields for the current beat
  always_comb begin
    out_valid  = cur_valid;
    out_sender = cur.sender;
    out_blocks = cur.blocks;
    out_last   = is_last;
    out_char   = 8'h00;
    out_kind   = scfp_pkg::KIND_ACK;
    out_tx     = 8'h00;
    if (!cur.is_ack) begin
      out_kind = scfp_pkg::KIND_READ;
      out_char = cur.read_char;
    end else begin
      unique case (beat)
        BeatOpen:  out_tx = scfp_pkg::CH_START;
        BeatAck:   out_tx = scfp_pkg::CH_ACK;
        BeatId:    out_tx = cur.ack_id;
        BeatClose: out_tx = scfp_pkg::CH_STOP;
        default:   out_kind = scfp_pkg::KIND_DONE;
      endcase
    end
  end

  // a read reply is a single transfer, bursts stop at the done beat
  `ASSERT_IMPLIES(read_one_beat, clk, rst, cur_valid && !cur.is_ack, beat == BeatOpen)
  `ASSERT_ALWAYS(beat_bound, clk, rst, beat <= BeatDone)

endmodule

// ===== dv/scfp_frame_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame parser checker
// Watches both stream channels of the serial command frame parser, keeps its
// own copy of the parse state and stored block text, and works out the
// acknowledge bursts and read replies owed for every input transfer. Each
// output transfer is compared field by field with the oldest owed result.
// ---------------------------------------------------------------------------
module scfp_frame_checker #(
  parameter int MAX_BLOCKS  = 3,
  parameter int COMMAND_LEN = 3,
  parameter int MESSAGE_LEN = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,  // rx_byte[7:0], read_block[9:8], read_pos[13:10], zero
  input  logic        s_tuser,  // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,  // tx_byte, frame_sender, frame_blocks, read_char
  input  logic [1:0]  m_tuser,  // kind
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_count,
  output int          frames_acked,
  output int          replies_checked
);

  localparam int BLOCK_CHARS = COMMAND_LEN + MESSAGE_LEN;

  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_SENDER     = 3'd1,
    PH_LENGTH     = 3'd2,
    PH_COMMAND    = 3'd3,
    PH_MESSAGE    = 3'd4,
    PH_ACK_ID     = 3'd5,
    PH_CHECK      = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] sender;
    logic [7:0] blocks;
    logic [7:0] read_char;
    logic       last;
  } result_t;

  // parser copy
  phase_t     phase;
  logic [7:0] sender;
  logic [7:0] block_total;
  logic [7:0] blocks_left;
  int         slot;
  int         command_fill;
  int         message_fill;
  logic [7:0] work_text [BLOCK_CHARS];
  logic [7:0] stored_text [MAX_BLOCKS * BLOCK_CHARS];
  logic [7:0] ack_id;
  logic [7:0] check_value;

  result_t owed_results [$];
  int      mismatches = 0;
  int      acked = 0;
  int      replies = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_model();
    phase        = PH_WAIT_START;
    sender       = '0;
    block_total  = '0;
    blocks_left  = '0;
    slot         = 0;
    command_fill = 0;
    message_fill = 0;
    ack_id       = '0;
    check_value  = '0;
    foreach (work_text[i]) work_text[i] = '0;
    foreach (stored_text[i]) stored_text[i] = '0;
    owed_results.delete();
  endfunction

  function automatic void owe(input logic [1:0] kind, input logic [7:0] tx,
                              input logic [7:0] ch, input logic last);
    result_t r;
    r.kind      = kind;
    r.tx_byte   = tx;
    r.sender    = sender;
    r.blocks    = block_total;
    r.read_char = ch;
    r.last      = last;
    owed_results.push_back(r);
  endfunction

  // closing separator of a message: terminate, store if a slot is free, reset the work area
  function automatic void commit_block_text();
    if (message_fill < MESSAGE_LEN) work_text[COMMAND_LEN + message_fill] = '0;
    if (slot < MAX_BLOCKS) begin
      for (int i = 0; i < BLOCK_CHARS; i++) stored_text[slot * BLOCK_CHARS + i] = work_text[i];
      slot++;
    end
    foreach (work_text[i]) work_text[i] = '0;
    command_fill = 0;
    message_fill = 0;
    blocks_left  = blocks_left - 8'd1;
    phase        = (blocks_left == 8'd0) ? PH_ACK_ID : PH_COMMAND;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    case (phase)
      PH_WAIT_START: begin
        if (b == scfp_pkg::CH_START) begin
          sender       = '0;
          block_total  = '0;
          blocks_left  = '0;
          slot         = 0;
          command_fill = 0;
          message_fill = 0;
          phase        = PH_SENDER;
        end
      end
      PH_SENDER: begin
        if (b == scfp_pkg::CH_SEP) phase = PH_LENGTH;
        else sender = b;
      end
      PH_LENGTH: begin
        if (b == scfp_pkg::CH_SEP) begin
          phase = PH_COMMAND;
        end else begin
          block_total = b - scfp_pkg::CH_ZERO;
          blocks_left = block_total;
        end
      end
      PH_COMMAND: begin
        if (b == scfp_pkg::CH_SEP) begin
          if (command_fill < COMMAND_LEN) work_text[command_fill] = '0;
          phase = PH_MESSAGE;
        end else if (command_fill < COMMAND_LEN) begin
          work_text[command_fill] = b;
          command_fill++;
        end
      end
      PH_MESSAGE: begin
        if (b == scfp_pkg::CH_SEP) begin
          commit_block_text();
        end else if (message_fill < MESSAGE_LEN) begin
          work_text[COMMAND_LEN + message_fill] = b;
          message_fill++;
        end
      end
      PH_ACK_ID: begin
        if (b == scfp_pkg::CH_SEP) phase = PH_CHECK;
        else ack_id = b;
      end
      PH_CHECK: begin
        if (b == scfp_pkg::CH_STOP) begin
          phase = PH_WAIT_START;
          owe(scfp_pkg::KIND_ACK, scfp_pkg::CH_START, 8'h00, 1'b0);
          owe(scfp_pkg::KIND_ACK, scfp_pkg::CH_ACK, 8'h00, 1'b0);
          owe(scfp_pkg::KIND_ACK, ack_id, 8'h00, 1'b0);
          owe(scfp_pkg::KIND_ACK, scfp_pkg::CH_STOP, 8'h00, 1'b0);
          owe(scfp_pkg::KIND_DONE, 8'h00, 8'h00, 1'b1);
        end else begin
          check_value = b;
        end
      end
      default: phase = PH_WAIT_START;
    endcase
  endfunction

  function automatic void reply_read(input int blk, input int pos);
    logic [7:0] ch;
    ch = '0;
    if (blk < MAX_BLOCKS && pos < BLOCK_CHARS) ch = stored_text[blk * BLOCK_CHARS + pos];
    owe(scfp_pkg::KIND_READ, 8'h00, ch, 1'b1);
  endfunction

  // output side is checked before the input of the same edge is modeled:
  // nothing leaves in the cycle its cause is accepted
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_model();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("transfer with nothing owed, tdata", m_tdata, '0);
        end else begin
          want = owed_results.pop_front();
          if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
          if (m_tdata[7:0] !== want.tx_byte) report_mismatch("tx_byte", m_tdata[7:0], want.tx_byte);
          if (m_tdata[15:8] !== want.sender)
            report_mismatch("frame_sender", m_tdata[15:8], want.sender);
          if (m_tdata[23:16] !== want.blocks)
            report_mismatch("frame_blocks", m_tdata[23:16], want.blocks);
          if (m_tdata[31:24] !== want.read_char)
            report_mismatch("read_char", m_tdata[31:24], want.read_char);
          if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
          if (want.kind == scfp_pkg::KIND_DONE) acked++;
          if (want.kind == scfp_pkg::KIND_READ) replies++;
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) reply_read(s_tdata[9:8], s_tdata[13:10]);
        else parse_rx_byte(s_tdata[7:0]);
      end
    end
    fail_count      <= mismatches;
    pending_count   <= owed_results.size();
    frames_acked    <= acked;
    replies_checked <= replies;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame parser testbench
// Drives received bytes and read requests into the serial command frame
// parser: one hand-built frame, then random well-formed frames with
// random text, stray bytes and reads mixed in. Both stream sides idle at
// random.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int MAX_BLOCKS   = 3;
  localparam int COMMAND_LEN  = 3;
  localparam int MESSAGE_LEN  = 10;
  localparam int ITEM_TARGET  = 130;
  localparam int LIMIT_CYCLES = 300000;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // rx_byte[7:0], read_block[9:8], read_pos[13:10], zero
  logic        s_tuser = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // tx_byte, frame_sender, frame_blocks, read_char
  logic [1:0]  m_tuser;        // kind
  logic        m_tlast;

  int fail_count;
  int pending_count;
  int frames_acked;
  int replies_checked;
  int items_sent = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  serial_command_frame_parser #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .COMMAND_LEN(COMMAND_LEN),
    .MESSAGE_LEN(MESSAGE_LEN)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  scfp_frame_checker #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .COMMAND_LEN(COMMAND_LEN),
    .MESSAGE_LEN(MESSAGE_LEN)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .frames_acked   (frames_acked),
    .replies_checked(replies_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output side: random stall before each transfer
  initial begin : sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // one input transfer after a random gap; valid stays high across back-to-back items
  task automatic transfer(input logic mode, input logic [7:0] b, input logic [1:0] blk,
                          input logic [3:0] pos, input bit counted);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, pos, blk, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  // read fields are random on byte transfers and the byte is random on reads
  task automatic send_byte(input logic [7:0] b);
    transfer(1'b0, b, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b1);
  endtask

  task automatic send_read(input logic [1:0] blk, input logic [3:0] pos);
    transfer(1'b1, 8'($urandom_range(0, 255)), blk, pos, 1'b1);
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 4) == 0)
      send_read(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  // any byte that does not end the current field
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == scfp_pkg::CH_SEP) b = 8'h00;
    return b;
  endfunction

  task automatic send_text(input int n);
    repeat (n) begin
      maybe_read();
      send_byte(text_byte());
    end
  endtask

  // stray bytes between frames, never a start
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom_range(0, 255));
      if (b == scfp_pkg::CH_START) b = scfp_pkg::CH_STOP;
      transfer(1'b0, b, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0);
    end
  endtask

  task automatic random_frame();
    int blocks;
    int pick;
    logic [7:0] b;
    send_byte(scfp_pkg::CH_START);
    send_text($urandom_range(0, 2));
    send_byte(scfp_pkg::CH_SEP);
    // an earlier length byte is overwritten by the last one
    if ($urandom_range(0, 3) == 0) send_byte(text_byte());
    pick = $urandom_range(0, 9);
    if (pick < 6) blocks = $urandom_range(1, MAX_BLOCKS);
    else if (pick < 8) blocks = $urandom_range(MAX_BLOCKS + 1, 6);
    else if (pick < 9) blocks = $urandom_range(7, 9);
    else blocks = $urandom_range(11, 16);
    send_byte(8'(scfp_pkg::CH_ZERO + blocks));
    send_byte(scfp_pkg::CH_SEP);
    repeat (blocks) begin
      send_text($urandom_range(0, COMMAND_LEN + 2));
      send_byte(scfp_pkg::CH_SEP);
      if ($urandom_range(0, 2) == 0) send_text($urandom_range(0, MESSAGE_LEN + 3));
      else send_text($urandom_range(0, 4));
      send_byte(scfp_pkg::CH_SEP);
    end
    send_text($urandom_range(0, 2));
    send_byte(scfp_pkg::CH_SEP);
    repeat ($urandom_range(0, 2)) begin
      maybe_read();
      b = 8'($urandom_range(0, 255));
      if (b == scfp_pkg::CH_STOP) b = scfp_pkg::CH_SEP;
      send_byte(b);
    end
    send_byte(scfp_pkg::CH_STOP);
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reads of untouched storage, in and out of range
    send_read(2'd0, 4'd0);
    send_read(2'd3, 4'd15);
    // ignored while waiting for a start
    send_byte(8'h00);
    send_byte(8'hFF);
    // two blocks: repeated id and length bytes, command overflow, empty fields
    send_byte(scfp_pkg::CH_START);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(scfp_pkg::CH_SEP);
    send_byte(8'h2F);
    send_byte(scfp_pkg::CH_ZERO + 8'd2);
    send_byte(scfp_pkg::CH_SEP);
    send_byte("x");
    send_byte("y");
    send_byte("z");
    send_byte("w");
    send_byte(scfp_pkg::CH_SEP);
    send_byte(scfp_pkg::CH_SEP);
    send_byte(scfp_pkg::CH_SEP);
    send_byte("m");
    send_byte(scfp_pkg::CH_SEP);
    send_byte("Q");
    send_byte(scfp_pkg::CH_SEP);
    send_byte(8'hFF);
    send_byte(scfp_pkg::CH_STOP);
    send_read(2'd0, 4'd0);
    send_read(2'd0, 4'd3);
    send_read(2'd1, 4'd12);
    send_read(2'd2, 4'd0);

    // random frames with stray bytes and reads in between
    while (items_sent < ITEM_TARGET - 40) begin
      steady = ($urandom_range(0, 3) == 0);
      send_noise();
      random_frame();
      maybe_read();
    end
    steady = 1'b0;
    repeat (8) send_read(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    s_tvalid <= 1'b0;

    // drain, then wait for anything unowed to show up
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d input transfers; %0d frames acknowledged, %0d read replies checked",
             items_sent, frames_acked, replies_checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/scfp_pkg.sv
src/scfp_parser.sv
src/scfp_event_fifo.sv
src/scfp_ack_serializer.sv
src/serial_command_frame_parser.sv
dv/scfp_frame_checker.sv
dv/tb_top.sv
